### design/i2c_eeprom_master_sequencer_core_defines.svh
// Assertion macros used by the checker module i2cem_chk.
`ifndef I2C_EEPROM_MASTER_SEQUENCER_CORE_DEFINES_SVH
`define I2C_EEPROM_MASTER_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/i2cem_pkg.sv
package i2cem_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 4;
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_TX,
    PH_RSTART,
    PH_RX,
    PH_STOP
  } phase_t;

  localparam logic [3:0] SEL_DEVW  = 4'd0;
  localparam logic [3:0] SEL_WORD  = 4'd1;
  localparam logic [3:0] SEL_WBYTE = 4'd2;
  localparam logic [3:0] SEL_PAGE0 = 4'd3;
  localparam logic [3:0] SEL_PAGE1 = 4'd4;
  localparam logic [3:0] SEL_PAGE2 = 4'd5;
  localparam logic [3:0] SEL_PAGE3 = 4'd6;
  localparam logic [3:0] SEL_DEVR  = 4'd12;

  localparam logic [1:0] MODE_BYTE_WR = 2'd0;
  localparam logic [1:0] MODE_PAGE_WR = 2'd1;
  localparam logic [1:0] MODE_RAND_RD = 2'd2;
  localparam logic [1:0] MODE_SEQ_RD  = 2'd3;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_DEV_ADDR   = 3'd1;
  localparam logic [2:0] REG_WORD_ADDR  = 3'd2;
  localparam logic [2:0] REG_WRITE_BYTE = 3'd3;
  localparam logic [2:0] REG_READ_COUNT = 3'd4;
  localparam logic [2:0] REG_PAGE_WORD  = 3'd5;

  localparam logic [1:0]  RST_MODE       = MODE_SEQ_RD;
  localparam logic [6:0]  RST_DEV_ADDR   = 7'd80;
  localparam logic [7:0]  RST_WORD_ADDR  = 8'd85;
  localparam logic [7:0]  RST_WRITE_BYTE = 8'd240;
  localparam logic [7:0]  RST_READ_COUNT = 8'd10;
  localparam logic [31:0] RST_PAGE_WORD  = 32'd296222684;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  dev_addr;
    logic [7:0]  word_addr;
    logic [7:0]  write_byte;
    logic [7:0]  read_count;
    logic [31:0] page_word;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] quarter;
    logic [3:0] bitpos;
    logic [3:0] sel;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic [7:0] rx_done;
    logic [1:0] lat_mode;
    logic [7:0] lat_count;
  } seq_state_t;

  function automatic logic [7:0] byte_for(input logic [3:0] s, input cfg_t c);
    logic [7:0] b;
    case (s)
      SEL_DEVW:  b = {c.dev_addr, 1'b0};
      SEL_DEVR:  b = {c.dev_addr, 1'b1};
      SEL_WORD:  b = c.word_addr;
      SEL_WBYTE: b = c.write_byte;
      SEL_PAGE0: b = c.page_word[31:24];
      SEL_PAGE1: b = c.page_word[23:16];
      SEL_PAGE2: b = c.page_word[15:8];
      SEL_PAGE3: b = c.page_word[7:0];
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

### design/i2cem_if.sv
interface i2cem_in_if;
  logic                valid;
  logic                ready;
  i2cem_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cem_out_if;
  logic                 valid;
  logic                 ready;
  i2cem_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/i2cem_cfg.sv
module i2cem_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2cem_pkg::CFG_AW-1:0]    paddr,
  input  logic [i2cem_pkg::CFG_DW-1:0]    pwdata,
  output logic [i2cem_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready,
  output i2cem_pkg::cfg_t                 cfg
);

  i2cem_pkg::cfg_t cfg_r;
  i2cem_pkg::cfg_t cfg_nxt;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        i2cem_pkg::REG_MODE:       cfg_nxt.mode       = pwdata[1:0];
        i2cem_pkg::REG_DEV_ADDR:   cfg_nxt.dev_addr   = pwdata[6:0];
        i2cem_pkg::REG_WORD_ADDR:  cfg_nxt.word_addr  = pwdata[7:0];
        i2cem_pkg::REG_WRITE_BYTE: cfg_nxt.write_byte = pwdata[7:0];
        i2cem_pkg::REG_READ_COUNT: cfg_nxt.read_count = pwdata[7:0];
        i2cem_pkg::REG_PAGE_WORD:  cfg_nxt.page_word  = pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      i2cem_pkg::REG_MODE:       prdata = {30'd0, cfg_r.mode};
      i2cem_pkg::REG_DEV_ADDR:   prdata = {25'd0, cfg_r.dev_addr};
      i2cem_pkg::REG_WORD_ADDR:  prdata = {24'd0, cfg_r.word_addr};
      i2cem_pkg::REG_WRITE_BYTE: prdata = {24'd0, cfg_r.write_byte};
      i2cem_pkg::REG_READ_COUNT: prdata = {24'd0, cfg_r.read_count};
      i2cem_pkg::REG_PAGE_WORD:  prdata = cfg_r.page_word;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= i2cem_pkg::RST_MODE;
      cfg_r.dev_addr   <= i2cem_pkg::RST_DEV_ADDR;
      cfg_r.word_addr  <= i2cem_pkg::RST_WORD_ADDR;
      cfg_r.write_byte <= i2cem_pkg::RST_WRITE_BYTE;
      cfg_r.read_count <= i2cem_pkg::RST_READ_COUNT;
      cfg_r.page_word  <= i2cem_pkg::RST_PAGE_WORD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/i2cem_step.sv
module i2cem_step #(
  parameter int unsigned PAGE_BYTES = i2cem_pkg::PAGE_BYTES_DEF
) (
  input  i2cem_pkg::seq_state_t st,
  input  i2cem_pkg::cfg_t       cfg,
  input  i2cem_pkg::in_item_t   item,
  output i2cem_pkg::seq_state_t st_nxt,
  output i2cem_pkg::out_item_t  res
);

  localparam logic [3:0] PAGE_END = 4'(PAGE_BYTES + 2);

  logic       last_q;
  logic       mid_high;
  logic       rx_last;
  logic [3:0] bp_inc;
  logic [7:0] shift_in;

  assign last_q   = (st.quarter == 2'd3);
  assign mid_high = (st.quarter == 2'd1) || (st.quarter == 2'd2);
  assign rx_last  = ({1'b0, st.rx_done} + 9'd1) >= {1'b0, st.lat_count};
  assign bp_inc   = st.bitpos + 4'd1;
  assign shift_in = {st.rx_shift[6:0], item.sda_in};

  always_comb begin
    logic       do_begin;
    logic [3:0] begin_sel;
    logic [1:0] q_cur;

    do_begin  = 1'b0;
    begin_sel = i2cem_pkg::SEL_DEVW;
    q_cur     = st.quarter;
    st_nxt    = st;
    res       = '0;
    res.scl       = 1'b1;
    res.sda_drive = 1'b1;
    res.sda_level = 1'b1;
    res.busy_res  = (st.phase != i2cem_pkg::PH_IDLE);

    case (st.phase)
      i2cem_pkg::PH_START, i2cem_pkg::PH_RSTART: begin
        res.scl       = (st.quarter == 2'd0) ? (st.phase == i2cem_pkg::PH_START) : !last_q;
        res.sda_level = !st.quarter[1];
        if (last_q) begin
          do_begin  = 1'b1;
          begin_sel = (st.phase == i2cem_pkg::PH_RSTART) ? i2cem_pkg::SEL_DEVR
                                                         : i2cem_pkg::SEL_DEVW;
        end
      end
      i2cem_pkg::PH_TX: begin
        res.scl = mid_high;
        if (!st.bitpos[3]) begin
          res.sda_level = st.tx_shift[~st.bitpos[2:0]];
        end else begin
          res.sda_drive = 1'b0;
          res.sda_level = 1'b0;
        end
        if (last_q) begin
          st_nxt.bitpos = bp_inc;
          if (bp_inc >= 4'd9) begin
            case (st.sel)
              i2cem_pkg::SEL_DEVW: begin
                do_begin  = 1'b1;
                begin_sel = i2cem_pkg::SEL_WORD;
              end
              i2cem_pkg::SEL_WORD: begin
                if (st.lat_mode[1]) begin
                  st_nxt.phase = i2cem_pkg::PH_RSTART;
                end else begin
                  do_begin  = 1'b1;
                  begin_sel = i2cem_pkg::SEL_WBYTE;
                end
              end
              i2cem_pkg::SEL_WBYTE: begin
                if (st.lat_mode == i2cem_pkg::MODE_PAGE_WR) begin
                  do_begin  = 1'b1;
                  begin_sel = i2cem_pkg::SEL_PAGE0;
                end else begin
                  st_nxt.phase = i2cem_pkg::PH_STOP;
                end
              end
              i2cem_pkg::SEL_DEVR: begin
                st_nxt.phase    = i2cem_pkg::PH_RX;
                st_nxt.bitpos   = 4'd0;
                st_nxt.rx_shift = 8'd0;
                st_nxt.rx_done  = 8'd0;
              end
              default: begin
                if (st.sel < PAGE_END) begin
                  do_begin  = 1'b1;
                  begin_sel = st.sel + 4'd1;
                end else begin
                  st_nxt.phase = i2cem_pkg::PH_STOP;
                end
              end
            endcase
          end
        end
      end
      i2cem_pkg::PH_RX: begin
        res.scl = mid_high;
        if (!st.bitpos[3]) begin
          res.sda_drive = 1'b0;
          res.sda_level = 1'b0;
          if (st.quarter == 2'd2) begin
            st_nxt.rx_shift = shift_in;
            if (st.bitpos == 4'd7) begin
              res.read_valid = 1'b1;
              res.read_byte  = shift_in;
              res.read_last  = rx_last;
            end
          end
        end else begin
          res.sda_level = rx_last;
        end
        if (last_q) begin
          st_nxt.bitpos = bp_inc;
          if (bp_inc >= 4'd9) begin
            st_nxt.rx_done  = st.rx_done + 8'd1;
            st_nxt.bitpos   = 4'd0;
            st_nxt.rx_shift = 8'd0;
            if (rx_last) begin
              st_nxt.phase = i2cem_pkg::PH_STOP;
            end
          end
        end
      end
      i2cem_pkg::PH_STOP: begin
        res.scl       = (st.quarter != 2'd0);
        res.sda_level = last_q;
        if (last_q) begin
          res.done_res = 1'b1;
          st_nxt.phase = i2cem_pkg::PH_IDLE;
        end
      end
      default: begin
        st_nxt.phase = i2cem_pkg::PH_IDLE;
        if (item.start_req) begin
          st_nxt.lat_mode = cfg.mode;
          if (cfg.mode == i2cem_pkg::MODE_RAND_RD || cfg.read_count == 8'd0) begin
            st_nxt.lat_count = 8'd1;
          end else begin
            st_nxt.lat_count = cfg.read_count;
          end
          st_nxt.phase = i2cem_pkg::PH_START;
          q_cur        = 2'd3;
        end
      end
    endcase

    if (do_begin) begin
      st_nxt.sel      = begin_sel;
      st_nxt.tx_shift = i2cem_pkg::byte_for(begin_sel, cfg);
      st_nxt.bitpos   = 4'd0;
      st_nxt.phase    = i2cem_pkg::PH_TX;
    end
    st_nxt.quarter = q_cur + 2'd1;
  end

endmodule

### design/i2c_eeprom_master_sequencer_core.sv
// I2C master sequencer for a serial EEPROM: byte write, page write, random
// read and sequential read.
// Input channel in_if: one item per bus tick, carrying start_req and the
// sampled SDA level. Result channel out_if: one item per input item, with
// the SCL level, SDA drive and level, received byte flags and busy/done.
// Configuration: APB-style registers (mode, dev_addr, word_addr, write_byte,
// read_count, page_word) at byte addresses 0, 4, ... 20; pready is always
// high, writes land in the access cycle. Change registers only while idle.
// An accepted item is held in the input register, then stepped into the
// result register and offered on out_if until it is taken.
// Throughput: one item per cycle while out_if.ready is high; sequencer state
// is updated by one level of logic between the input and result registers.
// Each bus bit spans four items; a start pulse accepted while idle begins the
// transaction on the following tick.
// Reset (synchronous, rst_n low): both stages empty, sequencer idle,
// registers at their defaults.
// Stall: while out_if.ready is low the result holds and the input stage
// still takes one more item; the sequencer does not advance meanwhile.
module i2c_eeprom_master_sequencer_core #(
  parameter int unsigned PAGE_BYTES = i2cem_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  i2cem_in_if.sink                     in_if,
  i2cem_out_if.source                  out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cem_pkg::CFG_AW-1:0] paddr,
  input  logic [i2cem_pkg::CFG_DW-1:0] pwdata,
  output logic [i2cem_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);

  i2cem_pkg::cfg_t       cfg;
  i2cem_pkg::seq_state_t state_r;
  i2cem_pkg::seq_state_t state_nxt;
  i2cem_pkg::in_item_t   in_data_r;
  i2cem_pkg::in_item_t   in_data_nxt;
  i2cem_pkg::out_item_t  out_data_r;
  i2cem_pkg::out_item_t  out_data_nxt;
  i2cem_pkg::seq_state_t step_state;
  i2cem_pkg::out_item_t  step_res;
  logic                  in_v_r;
  logic                  in_v_nxt;
  logic                  out_v_r;
  logic                  out_v_nxt;
  logic                  in_fire;
  logic                  advance;

  i2cem_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cem_step #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_step (
    .st     (state_r),
    .cfg    (cfg),
    .item   (in_data_r),
    .st_nxt (step_state),
    .res    (step_res)
  );

  assign advance      = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !in_v_r || advance;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_data_r;

  always_comb begin
    in_v_nxt     = in_v_r;
    in_data_nxt  = in_data_r;
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    state_nxt    = state_r;
    if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end
    if (advance) begin
      in_v_nxt     = 1'b0;
      out_v_nxt    = 1'b1;
      out_data_nxt = step_res;
      state_nxt    = step_state;
    end
    if (in_fire) begin
      in_v_nxt    = 1'b1;
      in_data_nxt = in_if.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r            <= 1'b0;
      out_v_r           <= 1'b0;
      state_r.phase     <= i2cem_pkg::PH_IDLE;
      state_r.quarter   <= 2'd0;
      state_r.bitpos    <= 4'd0;
      state_r.sel       <= i2cem_pkg::SEL_DEVW;
      state_r.tx_shift  <= 8'd0;
      state_r.rx_shift  <= 8'd0;
      state_r.rx_done   <= 8'd0;
      state_r.lat_mode  <= i2cem_pkg::MODE_BYTE_WR;
      state_r.lat_count <= 8'd1;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### design/i2cem_chk.sv
`include "i2c_eeprom_master_sequencer_core_defines.svh"

module i2cem_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cem_pkg::out_item_t out_data
);

  `I2CEM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result item changed")

  `I2CEM_ASSERT_IMP(a_rx_released, out_valid && out_data.read_valid, !out_data.sda_drive && out_data.scl && out_data.busy_res, "read byte outside a released high clock")

  `I2CEM_ASSERT_IMP(a_stop_levels, out_valid && out_data.done_res, out_data.scl && out_data.sda_drive && out_data.sda_level && out_data.busy_res && !out_data.read_valid, "done without stop levels")

  `I2CEM_ASSERT_IMP(a_last_flag, out_valid && out_data.read_last, out_data.read_valid, "last flag without read byte")

endmodule

bind i2c_eeprom_master_sequencer_core i2cem_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
